// ===== hdl/owm_pkg.sv =====
package owm_pkg;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_RST_LOW   = 4'd1,
      PH_RST_REL   = 4'd2,
      PH_PRES_WAIT = 4'd3,
      PH_PRES_LOW  = 4'd4,
      PH_WR_LOW    = 4'd5,
      PH_WR_HIGH   = 4'd6,
      PH_RD_LOW    = 4'd7,
      PH_RD_SAMPLE = 4'd8,
      PH_RD_REST   = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_RESET = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_RESET_LOW     = 3'd0,
      CSR_RESET_RELEASE = 3'd1,
      CSR_PRES_WAIT     = 3'd2,
      CSR_PRES_LOW      = 3'd3,
      CSR_WRITE_ONE     = 3'd4,
      CSR_WRITE_ZERO    = 3'd5,
      CSR_READ_INIT     = 3'd6,
      CSR_READ_REST     = 3'd7
   } csr_index_type;

   localparam int TIMER_W = 10;
   localparam int CSR_W   = 10;

   localparam logic [9:0] RESET_LOW_DEFAULT     = 10'd750;
   localparam logic [5:0] RESET_RELEASE_DEFAULT = 6'd15;
   localparam logic [7:0] PRES_WAIT_DEFAULT     = 8'd100;
   localparam logic [8:0] PRES_LOW_DEFAULT      = 9'd240;
   localparam logic [3:0] WRITE_ONE_DEFAULT     = 4'd8;
   localparam logic [6:0] WRITE_ZERO_DEFAULT    = 7'd70;
   localparam logic [3:0] READ_INIT_DEFAULT     = 4'd10;
   localparam logic [6:0] READ_REST_DEFAULT     = 7'd45;

   localparam logic [TIMER_W-1:0] WR_ONE_HIGH  = 10'd58;
   localparam logic [TIMER_W-1:0] WR_ZERO_HIGH = 10'd2;
   localparam logic [TIMER_W-1:0] TIMER_ONE    = 10'd1;
   localparam logic [TIMER_W-1:0] TIMER_ZERO   = 10'd0;
   localparam logic [2:0]         LAST_BIT     = 3'd7;

   function automatic logic [TIMER_W-1:0] at_least_one(input logic [TIMER_W-1:0] v);
      at_least_one = (v == TIMER_ZERO) ? TIMER_ONE : v;
   endfunction

endpackage

// ===== hdl/one_wire_bus_master_unit.sv =====
// one-wire bus master, one transaction per microsecond tick
//
// req channel: one transaction per tick with the sampled bus level and an
// opcode (plain tick, reset and presence, write byte, read byte) plus the
// byte to write. a command is only taken while the master is idle.
// rsp channel: one transaction per req transaction with the bus drive for
// that tick, busy, done, the last presence result and the last read byte.
// csr channel: writes one of eight timing registers by index, always ready;
// write it only while no operation is running.
// response: registered, it appears in the cycle after the req transaction.
// throughput: one transaction per cycle while rsp does not stall; the whole tick update is one pass
// of logic from the state registers into the response register.
// when rsp stalls the response register holds and req_ready drops until it
// is taken; req_ready is high while the response register is empty or
// being taken in the same cycle.
// reset: phase idle, counters and bytes zero, presence ok, timing registers
// back to their defaults, no response pending.
module one_wire_bus_master_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [7:0] req_write_data,
   input  logic       req_line_level,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_drive_low,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic       rsp_presence_fail,
   output logic [7:0] rsp_read_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [owm_pkg::CSR_W-1:0] csr_data
);
   import owm_pkg::*;

   logic [9:0] reset_low_ff;
   logic [5:0] reset_release_ff;
   logic [7:0] pres_wait_ff;
   logic [8:0] pres_low_ff;
   logic [3:0] write_one_ff;
   logic [6:0] write_zero_ff;
   logic [3:0] read_init_ff;
   logic [6:0] read_rest_ff;

   phase_type            phase_ff, phase_in, ph_s;
   logic [TIMER_W-1:0]   timer_ff, timer_in, tmr_s, tmr_inc;
   logic [2:0]           bit_ff, bit_in, bit_s, bit_nx;
   logic [7:0]           shift_ff, shift_in, sb_s;
   logic                 fail_ff, fail_in;
   logic [7:0]           rbyte_ff, rbyte_in;

   logic                 rsp_valid_ff;
   logic                 drive_ff, busy_ff, done_ff;
   logic                 drive_in, busy_in, done_in;

   logic                 req_take;
   logic                 csr_take;

   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff     <= RESET_LOW_DEFAULT;
         reset_release_ff <= RESET_RELEASE_DEFAULT;
         pres_wait_ff     <= PRES_WAIT_DEFAULT;
         pres_low_ff      <= PRES_LOW_DEFAULT;
         write_one_ff     <= WRITE_ONE_DEFAULT;
         write_zero_ff    <= WRITE_ZERO_DEFAULT;
         read_init_ff     <= READ_INIT_DEFAULT;
         read_rest_ff     <= READ_REST_DEFAULT;
      end else if (csr_take) begin
         case (csr_index_type'(csr_index))
            CSR_RESET_LOW:     reset_low_ff     <= csr_data[9:0];
            CSR_RESET_RELEASE: reset_release_ff <= csr_data[5:0];
            CSR_PRES_WAIT:     pres_wait_ff     <= csr_data[7:0];
            CSR_PRES_LOW:      pres_low_ff      <= csr_data[8:0];
            CSR_WRITE_ONE:     write_one_ff     <= csr_data[3:0];
            CSR_WRITE_ZERO:    write_zero_ff    <= csr_data[6:0];
            CSR_READ_INIT:     read_init_ff     <= csr_data[3:0];
            CSR_READ_REST:     read_rest_ff     <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // command start
   always_comb begin
      ph_s  = (phase_ff > PH_RD_REST) ? PH_IDLE : phase_ff;
      tmr_s = timer_ff;
      bit_s = bit_ff;
      sb_s  = shift_ff;
      if (ph_s == PH_IDLE) begin
         case (opcode_type'(req_opcode))
            OP_RESET: begin
               bit_s = 3'd0;
               ph_s  = PH_RST_LOW;
               tmr_s = at_least_one(reset_low_ff);
            end
            OP_WRITE: begin
               bit_s = 3'd0;
               sb_s  = req_write_data;
               ph_s  = PH_WR_LOW;
               tmr_s = req_write_data[0] ? at_least_one({6'd0, write_one_ff})
                                         : at_least_one({3'd0, write_zero_ff});
            end
            OP_READ: begin
               bit_s = 3'd0;
               sb_s  = 8'd0;
               ph_s  = PH_RD_LOW;
               tmr_s = at_least_one({6'd0, read_init_ff});
            end
            default: ;
         endcase
      end
   end

   assign tmr_inc = tmr_s + TIMER_ONE;
   assign bit_nx  = bit_s + 3'd1;

   // next state
   always_comb begin
      phase_in = ph_s;
      timer_in = tmr_s;
      bit_in   = bit_s;
      shift_in = sb_s;
      fail_in  = fail_ff;
      rbyte_in = rbyte_ff;
      case (ph_s)
         PH_IDLE: ;
         PH_PRES_WAIT: begin
            if (tmr_s >= {2'd0, pres_wait_ff}) begin
               fail_in  = 1'b1;
               phase_in = PH_IDLE;
               timer_in = TIMER_ZERO;
            end else if (req_line_level) begin
               if (tmr_inc >= {2'd0, pres_wait_ff}) begin
                  fail_in  = 1'b1;
                  phase_in = PH_IDLE;
                  timer_in = TIMER_ZERO;
               end else begin
                  timer_in = tmr_inc;
               end
            end else if (pres_low_ff <= 9'd1) begin
               fail_in  = 1'b1;
               phase_in = PH_IDLE;
               timer_in = TIMER_ZERO;
            end else begin
               phase_in = PH_PRES_LOW;
               timer_in = TIMER_ONE;
            end
         end
         PH_PRES_LOW: begin
            if (req_line_level) begin
               fail_in  = 1'b0;
               phase_in = PH_IDLE;
               timer_in = TIMER_ZERO;
            end else if (tmr_inc >= {1'b0, pres_low_ff}) begin
               fail_in  = 1'b1;
               phase_in = PH_IDLE;
               timer_in = TIMER_ZERO;
            end else begin
               timer_in = tmr_inc;
            end
         end
         default: begin
            if (ph_s == PH_RD_SAMPLE && req_line_level) begin
               shift_in[bit_s] = 1'b1;
            end
            if (tmr_s > TIMER_ONE) begin
               timer_in = tmr_s - TIMER_ONE;
            end else begin
               case (ph_s)
                  PH_RST_LOW: begin
                     if (reset_release_ff == 6'd0) begin
                        phase_in = PH_PRES_WAIT;
                        timer_in = TIMER_ZERO;
                     end else begin
                        phase_in = PH_RST_REL;
                        timer_in = {4'd0, reset_release_ff};
                     end
                  end
                  PH_RST_REL: begin
                     phase_in = PH_PRES_WAIT;
                     timer_in = TIMER_ZERO;
                  end
                  PH_WR_LOW: begin
                     phase_in = PH_WR_HIGH;
                     timer_in = sb_s[bit_s] ? WR_ONE_HIGH : WR_ZERO_HIGH;
                  end
                  PH_WR_HIGH: begin
                     if (bit_s == LAST_BIT) begin
                        phase_in = PH_IDLE;
                        timer_in = TIMER_ZERO;
                     end else begin
                        bit_in   = bit_nx;
                        phase_in = PH_WR_LOW;
                        timer_in = sb_s[bit_nx] ? at_least_one({6'd0, write_one_ff})
                                                : at_least_one({3'd0, write_zero_ff});
                     end
                  end
                  PH_RD_LOW: begin
                     phase_in = PH_RD_SAMPLE;
                     timer_in = TIMER_ONE;
                  end
                  PH_RD_SAMPLE, PH_RD_REST: begin
                     if (ph_s == PH_RD_SAMPLE && read_rest_ff != 7'd0) begin
                        phase_in = PH_RD_REST;
                        timer_in = {3'd0, read_rest_ff};
                     end else if (bit_s == LAST_BIT) begin
                        rbyte_in = shift_in;
                        phase_in = PH_IDLE;
                        timer_in = TIMER_ZERO;
                     end else begin
                        bit_in   = bit_nx;
                        phase_in = PH_RD_LOW;
                        timer_in = at_least_one({6'd0, read_init_ff});
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     timer_in = TIMER_ZERO;
                  end
               endcase
            end
         end
      endcase
   end

   // response fields
   always_comb begin
      drive_in = (ph_s == PH_RST_LOW) || (ph_s == PH_WR_LOW) || (ph_s == PH_RD_LOW);
      busy_in  = (phase_in != PH_IDLE);
      done_in  = (ph_s != PH_IDLE) && (phase_in == PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         timer_ff     <= TIMER_ZERO;
         bit_ff       <= 3'd0;
         shift_ff     <= 8'd0;
         fail_ff      <= 1'b0;
         rbyte_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            phase_ff     <= phase_in;
            timer_ff     <= timer_in;
            bit_ff       <= bit_in;
            shift_ff     <= shift_in;
            fail_ff      <= fail_in;
            rbyte_ff     <= rbyte_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         drive_ff <= drive_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_low     = drive_ff;
   assign rsp_busy_res      = busy_ff;
   assign rsp_done_res      = done_ff;
   assign rsp_presence_fail = fail_ff;
   assign rsp_read_data     = rbyte_ff;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> !busy_ff)
      else $error("done and busy in one response");

   a_drive_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && drive_ff |-> busy_ff)
      else $error("bus driven low with no operation running");

   a_busy_phase: assert property (@(posedge clock) disable iff (reset)
      req_take |=> busy_ff == (phase_ff != PH_IDLE))
      else $error("busy does not match phase");

   a_pres_low_timer: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PRES_LOW |-> timer_ff != TIMER_ZERO)
      else $error("presence low count is zero");

endmodule
